/* rtl/assert_macros.svh */
// Assertion macros shared by the oscillator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MWPO_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define MWPO_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define MWPO_ASSERT(label, clk, rstn, prop, msg)
`define MWPO_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

/* rtl/mwpo_pkg.sv */
// Package for the multi-waveform phase oscillator: sizes, codes and the sine table.
// Has no dependencies; used by the top level.
`timescale 1ns / 1ps
package mwpo_pkg;

    localparam int NUM_SLOTS    = 8;
    localparam int TABLE_LEN    = 1024;
    localparam int SINE_ENTRIES = 1024;

    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int TBL_BITS  = $clog2(TABLE_LEN);
    localparam int ADDR_BITS = SLOT_BITS + TBL_BITS;
    localparam int MEM_DEPTH = NUM_SLOTS * TABLE_LEN;
    localparam int SINE_BITS = $clog2(SINE_ENTRIES);
    localparam int QTR_BITS  = SINE_BITS - 2;
    localparam int QTR_LEN   = SINE_ENTRIES / 4;
    localparam int QIDX_W    = QTR_BITS + 1;

    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 32;
    localparam int RATIO_W    = 17;
    localparam int DEPTH_W    = 16;
    localparam int MIX_W      = 17;
    localparam int WAVE_W     = 3;
    localparam int SLOT_IN_W  = 3;
    localparam int ENTRY_IN_W = 10;
    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [WAVE_W-1:0] WAVE_SINE      = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE    = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE  = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAW       = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_CUSTOM    = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_WAVETABLE = 3'd5;
    localparam logic [WAVE_W-1:0] WAVE_FM        = 3'd6;
    localparam logic [WAVE_W-1:0] WAVE_RING      = 3'd7;

    localparam logic [REG_IDX_W-1:0] REG_WAVE_SELECT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MORPH       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FM_RATIO    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FM_DEPTH    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RING_RATIO  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_RING_MIX    = 3'd7;

    localparam logic [16:0] MORPH_MAX   = 17'd65536;
    localparam logic [16:0] RATIO_MIN   = 17'd410;
    localparam logic [16:0] RATIO_MAX   = 17'd65536;
    localparam logic [16:0] RATIO_RESET = 17'd4096;
    localparam logic [15:0] DEPTH_MAX   = 16'd40960;
    localparam logic [16:0] MIX_MAX     = 17'd65536;

    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    typedef logic signed [SAMPLE_W-1:0] qsine_t [0:QTR_LEN];

    function automatic logic signed [SAMPLE_W-1:0] sine_series_q(int unsigned m);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        int k;
        r = 64'(m) << (30 - QTR_BITS);
        x = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return SAMPLE_W'(v);
    endfunction

    function automatic qsine_t qsine_build();
        qsine_t t;
        int m;
        for (m = 0; m <= QTR_LEN; m++) begin
            t[m] = sine_series_q(m);
        end
        return t;
    endfunction

    localparam qsine_t QSINE = qsine_build();

    function automatic logic signed [SAMPLE_W-1:0] sine_entry(logic [SINE_BITS-1:0] idx);
        logic [1:0] q;
        logic [QIDX_W-1:0] mi;
        logic signed [SAMPLE_W-1:0] v;
        q = idx[SINE_BITS-1 -: 2];
        if (q[0]) begin
            mi = QIDX_W'(QTR_LEN) - {1'b0, idx[QTR_BITS-1:0]};
        end else begin
            mi = {1'b0, idx[QTR_BITS-1:0]};
        end
        v = QSINE[mi];
        return q[1] ? -v : v;
    endfunction

endpackage

/* rtl/mwpo_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Has no dependencies.
`timescale 1ns / 1ps
module mwpo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/multi_waveform_phase_oscillator.sv */
// Top level of the multi-waveform phase oscillator with its APB register file.
// Depends on mwpo_pkg, mwpo_ram and assert_macros.svh.
// One item is handled at a time. A wavetable write beat is written to memory as it is accepted.
// A tick beat passes through sequencer states that depend on the waveform: square, triangle
// and saw go through STEP, ADV and OUT; sine adds SLK, MUL and LRP before them; the custom
// table reads through TRD0, TRD1 and TRD2 before MUL and LRP; FM, ring and the wavetable morph
// run further passes. The sequencer shares one lerp multiplier and reads the wavetable memory
// through its single read port, one entry per cycle. The wavetable memory needs no clearing
// pass after reset. The next beat is accepted once the sample sits in the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multi_waveform_phase_oscillator (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [mwpo_pkg::PADDR_W-1:0]              paddr,
    input  logic [mwpo_pkg::PDATA_W-1:0]              pwdata,
    output logic [mwpo_pkg::PDATA_W-1:0]              prdata,
    output logic                                      pready,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic                                      s_opcode,
    input  logic [mwpo_pkg::SLOT_IN_W-1:0]            s_slot_index,
    input  logic [mwpo_pkg::ENTRY_IN_W-1:0]           s_entry_index,
    input  logic signed [mwpo_pkg::SAMPLE_W-1:0]      s_entry_value,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [mwpo_pkg::SAMPLE_W-1:0]      m_sample
);
    import mwpo_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_SLK  = 5'd1;
    localparam logic [4:0] ST_MUL  = 5'd2;
    localparam logic [4:0] ST_LRP  = 5'd3;
    localparam logic [4:0] ST_FM1  = 5'd4;
    localparam logic [4:0] ST_FM2  = 5'd5;
    localparam logic [4:0] ST_FM3  = 5'd6;
    localparam logic [4:0] ST_RG1  = 5'd7;
    localparam logic [4:0] ST_RG2  = 5'd8;
    localparam logic [4:0] ST_RG3  = 5'd9;
    localparam logic [4:0] ST_RG4  = 5'd10;
    localparam logic [4:0] ST_TRD0 = 5'd11;
    localparam logic [4:0] ST_TRD1 = 5'd12;
    localparam logic [4:0] ST_TRD2 = 5'd13;
    localparam logic [4:0] ST_STEP = 5'd14;
    localparam logic [4:0] ST_ADV  = 5'd15;
    localparam logic [4:0] ST_OUT  = 5'd16;

    localparam int MP_W = RATIO_W + SLOT_BITS;

    // Configuration registers.
    logic [WAVE_W-1:0]  wave_select_reg;
    logic               enable_reg;
    logic [PHASE_W-1:0] phase_step_reg;
    logic [16:0]        morph_reg;
    logic [RATIO_W-1:0] fm_ratio_reg;
    logic [DEPTH_W-1:0] fm_depth_reg;
    logic [RATIO_W-1:0] ring_ratio_reg;
    logic [MIX_W-1:0]   ring_mix_reg;
    logic               cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [16:0]        wd17;
    logic [15:0]        wd16;

    // Sequencer state and datapath registers.
    logic [4:0] state_reg, state_next;
    logic [1:0] pass_reg, pass_next;
    logic [PHASE_W-1:0] ph_reg, ph_next;
    logic signed [16:0] a_reg, a_next, b_reg, b_next;
    logic [15:0] f_reg, f_next;
    logic signed [33:0] lprod_reg, lprod_next;
    logic signed [15:0] c_reg, c_next, mv_reg, mv_next;
    logic signed [19:0] v_reg, v_next;
    logic signed [32:0] dm_reg, dm_next;
    logic signed [63:0] off_reg, off_next;
    logic signed [31:0] rprod_reg, rprod_next;
    logic signed [17:0] d_reg, d_next;
    logic signed [35:0] mprod_reg, mprod_next;
    logic [48:0] fs_reg, fs_next, rs_reg, rs_next;
    logic [SLOT_BITS-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [15:0] mf_reg, mf_next;
    logic [PHASE_W-1:0] carrier_phase_reg, carrier_phase_next;
    logic [PHASE_W-1:0] fm_mod_phase_reg, fm_mod_phase_next;
    logic [PHASE_W-1:0] ring_mod_phase_reg, ring_mod_phase_next;
    logic [NUM_SLOTS-1:0] slot_loaded_reg, slot_loaded_next;
    logic m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] m_sample_reg, m_sample_next;

    // Combinational helpers.
    logic s_fire, wr_ok;
    logic [SINE_BITS-1:0] s_i, s_j;
    logic [15:0] s_f, t_f;
    logic signed [15:0] sa, sb;
    logic [TBL_BITS-1:0] t_i, t_j;
    logic [SLOT_BITS-1:0] slot_cur;
    logic slot_ok;
    logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic signed [33:0] lrnd;
    logic signed [16:0] lerp_res;
    logic [MP_W-1:0] mpos;
    logic [MP_W-17:0] mlo;
    logic signed [63:0] offr;
    logic signed [31:0] prnd;
    logic signed [35:0] mrnd;

    function automatic logic signed [SAMPLE_W-1:0] sat16(logic signed [19:0] x);
        if (x > 20'sd32767) begin
            return 16'sh7FFF;
        end else if (x < -20'sd32768) begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

    // APB register file.
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign wd17    = pwdata[16:0];
    assign wd16    = pwdata[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_select_reg <= WAVE_SINE;
            enable_reg      <= 1'b0;
            phase_step_reg  <= '0;
            morph_reg       <= '0;
            fm_ratio_reg    <= RATIO_RESET;
            fm_depth_reg    <= '0;
            ring_ratio_reg  <= RATIO_RESET;
            ring_mix_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_WAVE_SELECT: wave_select_reg <= pwdata[WAVE_W-1:0];
                REG_ENABLE:      enable_reg <= pwdata[0];
                REG_PHASE_STEP:  phase_step_reg <= pwdata[PHASE_W-1:0];
                REG_MORPH:       morph_reg <= (wd17 > MORPH_MAX) ? MORPH_MAX : wd17;
                REG_FM_RATIO: begin
                    fm_ratio_reg <= (wd17 < RATIO_MIN) ? RATIO_MIN :
                                    (wd17 > RATIO_MAX) ? RATIO_MAX : wd17;
                end
                REG_FM_DEPTH:    fm_depth_reg <= (wd16 > DEPTH_MAX) ? DEPTH_MAX : wd16;
                REG_RING_RATIO: begin
                    ring_ratio_reg <= (wd17 < RATIO_MIN) ? RATIO_MIN :
                                      (wd17 > RATIO_MAX) ? RATIO_MAX : wd17;
                end
                REG_RING_MIX:    ring_mix_reg <= (wd17 > MIX_MAX) ? MIX_MAX : wd17;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WAVE_SELECT: prdata = PDATA_W'(wave_select_reg);
            REG_ENABLE:      prdata = PDATA_W'(enable_reg);
            REG_PHASE_STEP:  prdata = PDATA_W'(phase_step_reg);
            REG_MORPH:       prdata = PDATA_W'(morph_reg);
            REG_FM_RATIO:    prdata = PDATA_W'(fm_ratio_reg);
            REG_FM_DEPTH:    prdata = PDATA_W'(fm_depth_reg);
            REG_RING_RATIO:  prdata = PDATA_W'(ring_ratio_reg);
            REG_RING_MIX:    prdata = PDATA_W'(ring_mix_reg);
            default:         prdata = '0;
        endcase
    end

    // Wavetable memory.
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign wr_ok     = s_fire && (s_opcode == OP_WRITE)
                       && (32'(s_slot_index) < 32'(NUM_SLOTS))
                       && (32'(s_entry_index) < 32'(TABLE_LEN));
    assign ram_waddr = (ADDR_BITS'(s_slot_index) << TBL_BITS) | ADDR_BITS'(s_entry_index);

    assign t_i      = ph_reg[PHASE_W-1 -: TBL_BITS];
    assign t_j      = t_i + 1'b1;
    assign t_f      = ph_reg[PHASE_W-1-TBL_BITS -: 16];
    assign slot_cur = (wave_select_reg == WAVE_CUSTOM) ? '0 :
                      (pass_reg == 2'd0) ? lo_reg : hi_reg;
    assign slot_ok  = slot_loaded_reg[slot_cur];
    assign ram_raddr = (ADDR_BITS'(slot_cur) << TBL_BITS)
                       | ADDR_BITS'((state_reg == ST_TRD0) ? t_i : t_j);

    mwpo_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MEM_DEPTH)
    ) u_wave_ram (
        .aclk (aclk),
        .we   (wr_ok),
        .waddr(ram_waddr),
        .wdata(s_entry_value),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Sine table lookup and shared interpolation.
    assign s_i = ph_reg[PHASE_W-1 -: SINE_BITS];
    assign s_j = s_i + 1'b1;
    assign s_f = ph_reg[PHASE_W-1-SINE_BITS -: 16];
    assign sa  = sine_entry(s_i);
    assign sb  = sine_entry(s_j);

    assign lrnd     = (lprod_reg + 34'sd32768) >>> 16;
    assign lerp_res = a_reg + lrnd[16:0];

    assign mpos  = MP_W'(morph_reg) * MP_W'(NUM_SLOTS - 1);
    assign mlo   = mpos[MP_W-1:16];
    assign offr  = (off_reg + 64'sd67108864) >>> 27;
    assign prnd  = (rprod_reg + 32'sd16384) >>> 15;
    assign mrnd  = (mprod_reg + 36'sd32768) >>> 16;

    always_comb begin
        state_next          = state_reg;
        pass_next           = pass_reg;
        ph_next             = ph_reg;
        a_next              = a_reg;
        b_next              = b_reg;
        f_next              = f_reg;
        lprod_next          = lprod_reg;
        c_next              = c_reg;
        mv_next             = mv_reg;
        v_next              = v_reg;
        dm_next             = dm_reg;
        off_next            = off_reg;
        rprod_next          = rprod_reg;
        d_next              = d_reg;
        mprod_next          = mprod_reg;
        fs_next             = fs_reg;
        rs_next             = rs_reg;
        lo_next             = lo_reg;
        hi_next             = hi_reg;
        mf_next             = mf_reg;
        carrier_phase_next  = carrier_phase_reg;
        fm_mod_phase_next   = fm_mod_phase_reg;
        ring_mod_phase_next = ring_mod_phase_reg;
        slot_loaded_next    = slot_loaded_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_sample_next       = m_sample_reg;

        case (state_reg)
            ST_IDLE: begin
                if (wr_ok) begin
                    slot_loaded_next = slot_loaded_reg
                                       | (NUM_SLOTS'(1) << s_slot_index);
                end
                if (s_fire && s_opcode == OP_TICK) begin
                    pass_next = 2'd0;
                    ph_next   = carrier_phase_reg;
                    if (32'(mlo) > 32'(NUM_SLOTS - 1)) begin
                        lo_next = SLOT_BITS'(NUM_SLOTS - 1);
                    end else begin
                        lo_next = mlo[SLOT_BITS-1:0];
                    end
                    hi_next = (lo_next == SLOT_BITS'(NUM_SLOTS - 1)) ? lo_next
                                                                     : lo_next + 1'b1;
                    mf_next = mpos[15:0];
                    if (!enable_reg) begin
                        v_next     = '0;
                        state_next = ST_OUT;
                    end else begin
                        case (wave_select_reg)
                            WAVE_SQUARE: begin
                                v_next = carrier_phase_reg[PHASE_W-1] ? -20'sd32768
                                                                      : 20'sd32767;
                                state_next = ST_STEP;
                            end
                            WAVE_TRIANGLE: begin
                                case (carrier_phase_reg[PHASE_W-1 -: 2])
                                    2'b00:   v_next = $signed({3'b000,
                                                 carrier_phase_reg[PHASE_W-1:15]});
                                    2'b11:   v_next = $signed({3'b000,
                                                 carrier_phase_reg[PHASE_W-1:15]})
                                                 - 20'sd131072;
                                    default: v_next = 20'sd65536 - $signed({3'b000,
                                                 carrier_phase_reg[PHASE_W-1:15]});
                                endcase
                                state_next = ST_STEP;
                            end
                            WAVE_SAW: begin
                                v_next = $signed({4'b0000, carrier_phase_reg[PHASE_W-1:16]})
                                         - 20'sd32768;
                                state_next = ST_STEP;
                            end
                            WAVE_FM: begin
                                ph_next    = fm_mod_phase_reg;
                                state_next = ST_SLK;
                            end
                            WAVE_CUSTOM, WAVE_WAVETABLE: state_next = ST_TRD0;
                            default: state_next = ST_SLK;
                        endcase
                    end
                end
            end
            ST_SLK: begin
                a_next     = 17'(sa);
                b_next     = 17'(sb);
                f_next     = s_f;
                state_next = ST_MUL;
            end
            ST_TRD0: begin
                f_next     = t_f;
                state_next = ST_TRD1;
            end
            ST_TRD1: begin
                a_next     = slot_ok ? 17'($signed(ram_rdata)) : '0;
                state_next = ST_TRD2;
            end
            ST_TRD2: begin
                b_next     = slot_ok ? 17'($signed(ram_rdata)) : '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                lprod_next = (b_reg - a_reg) * $signed({1'b0, f_reg});
                state_next = ST_LRP;
            end
            ST_LRP: begin
                state_next = ST_STEP;
                case (wave_select_reg)
                    WAVE_WAVETABLE: begin
                        if (pass_reg == 2'd0) begin
                            c_next     = lerp_res[15:0];
                            pass_next  = 2'd1;
                            state_next = ST_TRD0;
                        end else if (pass_reg == 2'd1) begin
                            a_next     = 17'(c_reg);
                            b_next     = lerp_res;
                            f_next     = mf_reg;
                            pass_next  = 2'd2;
                            state_next = ST_MUL;
                        end else begin
                            v_next = 20'(lerp_res);
                        end
                    end
                    WAVE_FM: begin
                        if (pass_reg == 2'd0) begin
                            mv_next    = lerp_res[15:0];
                            state_next = ST_FM1;
                        end else begin
                            v_next = 20'(lerp_res);
                        end
                    end
                    WAVE_RING: begin
                        if (pass_reg == 2'd0) begin
                            c_next     = lerp_res[15:0];
                            pass_next  = 2'd1;
                            ph_next    = ring_mod_phase_reg;
                            state_next = ST_SLK;
                        end else begin
                            mv_next    = lerp_res[15:0];
                            state_next = ST_RG1;
                        end
                    end
                    default: v_next = 20'(lerp_res);
                endcase
            end
            ST_FM1: begin
                dm_next    = $signed({1'b0, fm_depth_reg}) * mv_reg;
                state_next = ST_FM2;
            end
            ST_FM2: begin
                off_next   = dm_reg * $signed({1'b0, INV_TWO_PI_Q32});
                state_next = ST_FM3;
            end
            ST_FM3: begin
                ph_next    = carrier_phase_reg + offr[PHASE_W-1:0];
                pass_next  = 2'd1;
                state_next = ST_SLK;
            end
            ST_RG1: begin
                rprod_next = c_reg * mv_reg;
                state_next = ST_RG2;
            end
            ST_RG2: begin
                d_next     = 18'(prnd) - 18'(c_reg);
                state_next = ST_RG3;
            end
            ST_RG3: begin
                mprod_next = d_reg * $signed({1'b0, ring_mix_reg});
                state_next = ST_RG4;
            end
            ST_RG4: begin
                v_next     = 20'(c_reg) + mrnd[19:0];
                state_next = ST_STEP;
            end
            ST_STEP: begin
                fs_next    = 49'(phase_step_reg) * 49'(fm_ratio_reg);
                rs_next    = 49'(phase_step_reg) * 49'(ring_ratio_reg);
                state_next = ST_ADV;
            end
            ST_ADV: begin
                carrier_phase_next  = carrier_phase_reg + phase_step_reg;
                fm_mod_phase_next   = fm_mod_phase_reg
                                      + 32'((fs_reg + 49'd2048) >> 12);
                ring_mod_phase_next = ring_mod_phase_reg
                                      + 32'((rs_reg + 49'd2048) >> 12);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = sat16(v_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            pass_reg           <= 2'd0;
            carrier_phase_reg  <= '0;
            fm_mod_phase_reg   <= '0;
            ring_mod_phase_reg <= '0;
            slot_loaded_reg    <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            pass_reg           <= pass_next;
            carrier_phase_reg  <= carrier_phase_next;
            fm_mod_phase_reg   <= fm_mod_phase_next;
            ring_mod_phase_reg <= ring_mod_phase_next;
            slot_loaded_reg    <= slot_loaded_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ph_reg       <= ph_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        f_reg        <= f_next;
        lprod_reg    <= lprod_next;
        c_reg        <= c_next;
        mv_reg       <= mv_next;
        v_reg        <= v_next;
        dm_reg       <= dm_next;
        off_reg      <= off_next;
        rprod_reg    <= rprod_next;
        d_reg        <= d_next;
        mprod_reg    <= mprod_next;
        fs_reg       <= fs_next;
        rs_reg       <= rs_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mf_reg       <= mf_next;
        m_sample_reg <= m_sample_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    `MWPO_ASSERT(a_disabled_tick_holds_phase, aclk, aresetn, (s_fire && s_opcode == OP_TICK && !enable_reg) |=> $stable(carrier_phase_reg), "Disabled tick moved the carrier phase.")
    `MWPO_ASSERT(a_result_from_out, aclk, aresetn, $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT), "Result beat raised outside the output state.")
    `MWPO_ASSERT(a_loaded_only_grows, aclk, aresetn, $past(aresetn) |-> ((slot_loaded_reg & $past(slot_loaded_reg)) == $past(slot_loaded_reg)), "A loaded slot was cleared.")
    `MWPO_NEVER(a_loaded_changes_idle, aclk, aresetn, $past(aresetn) && (slot_loaded_reg != $past(slot_loaded_reg)) && ($past(state_reg) != ST_IDLE), "Slot loaded flags changed while a tick was in progress.")

endmodule

/* bench/tb_multi_waveform_phase_oscillator.sv */
// Self-checking testbench for multi_waveform_phase_oscillator: each tick sample is predicted
// as the beat is queued, and register settings change over APB between phases.
// Depends on mwpo_pkg and the oscillator RTL.
`timescale 1ns / 1ps
module tb_multi_waveform_phase_oscillator;
    import mwpo_pkg::*;

    typedef struct packed {
        logic        op;
        logic [2:0]  slot;
        logic [9:0]  idx;
        logic [15:0] val;
    } osc_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0, s_ready;
    logic s_opcode = OP_TICK;
    logic [2:0] s_slot_index = '0;
    logic [9:0] s_entry_index = '0;
    logic signed [15:0] s_entry_value = '0;
    logic m_valid, m_ready = 1'b0;
    logic signed [15:0] m_sample;

    osc_beat_t beat_q[$];
    logic signed [15:0] sample_q[$];
    int errors = 0, ticks = 0, writes = 0, phases = 0, samples_seen = 0;

    // Predictor state.
    logic [2:0] p_wave;
    logic p_enable;
    logic [31:0] p_step, p_carrier, p_fm_phase, p_ring_phase;
    logic [16:0] p_morph, p_fm_ratio, p_ring_ratio, p_mix;
    logic [15:0] p_depth;
    logic signed [15:0] p_mem [0:MEM_DEPTH-1];
    logic p_written [0:MEM_DEPTH-1];
    logic [7:0] p_loaded;
    int sine_lut [0:1023];

    multi_waveform_phase_oscillator DUT (.*);

    always #5 aclk = ~aclk;

    function automatic longint round_shift(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic int clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int blend(int a, int b, logic [15:0] f);
        return a + int'(round_shift(longint'(b - a) * longint'(f), 16));
    endfunction

    function automatic int sine_poly(logic [31:0] p);
        logic [63:0] r, x, x2, term, sum, v;
        int k;
        r = {34'd0, p[29:0]};
        if (p[30]) r = (64'd1 << 30) - r;
        x = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        v = (sum + 64'd16384) >> 15;
        if (v > 64'd32767) v = 64'd32767;
        return p[31] ? -int'(v) : int'(v);
    endfunction

    function automatic int sine_of(logic [31:0] p);
        logic [9:0] i;
        i = p[31:22];
        return blend(sine_lut[i], sine_lut[10'(i + 1)], p[21:6]);
    endfunction

    function automatic int table_of(logic [31:0] p, int slot);
        logic [9:0] i;
        i = p[31:22];
        if (!p_loaded[slot]) return 0;
        return blend(p_mem[slot * 1024 + i], p_mem[slot * 1024 + 10'(i + 1)], p[21:6]);
    endfunction

    function automatic logic [31:0] mod_step(logic [16:0] ratio);
        logic [63:0] prod;
        prod = 64'(p_step) * 64'(ratio) + 64'd2048;
        return prod[43:12];
    endfunction

    function automatic logic [16:0] clamp17(logic [31:0] v, logic [16:0] lo, logic [16:0] hi);
        logic [16:0] m;
        m = v[16:0];
        return (m < lo) ? lo : ((m > hi) ? hi : m);
    endfunction

    task automatic morph_slots(output int lo, output int hi, output logic [15:0] f);
        logic [31:0] pos;
        pos = 32'(p_morph) * 32'd7;
        lo = int'(pos >> 16);
        if (lo > 7) lo = 7;
        hi = (lo + 1 < 8) ? lo + 1 : lo;
        f = 16'(pos - (32'(lo) << 16));
    endtask

    task automatic push_write(int slot, int idx, logic [15:0] val);
        osc_beat_t b;
        b.op = OP_WRITE;
        b.slot = 3'(slot);
        b.idx = 10'(idx);
        b.val = val;
        beat_q.push_back(b);
        p_mem[slot * 1024 + idx] = val;
        p_written[slot * 1024 + idx] = 1'b1;
        p_loaded[slot] = 1'b1;
        writes++;
    endtask

    // Loaded slots must never be read at an entry that has not been written yet.
    task automatic cover_entries(int slot);
        int i;
        i = int'(p_carrier[31:22]);
        if (!p_loaded[slot]) return;
        if (!p_written[slot * 1024 + i]) push_write(slot, i, 16'($urandom));
        i = (i + 1) % 1024;
        if (!p_written[slot * 1024 + i]) push_write(slot, i, 16'($urandom));
    endtask

    task automatic push_tick();
        osc_beat_t b;
        longint v, c, m, prod, off;
        int lo, hi;
        logic [15:0] f;
        v = 0;
        if (p_enable) begin
            if (p_wave == WAVE_CUSTOM) cover_entries(0);
            if (p_wave == WAVE_WAVETABLE) begin
                morph_slots(lo, hi, f);
                cover_entries(lo);
                cover_entries(hi);
            end
            case (p_wave)
                WAVE_SINE: v = sine_of(p_carrier);
                WAVE_SQUARE: v = p_carrier[31] ? -32768 : 32767;
                WAVE_TRIANGLE: begin
                    c = longint'(p_carrier >> 15);
                    if (p_carrier < 32'h4000_0000) v = c;
                    else if (p_carrier < 32'hC000_0000) v = 65536 - c;
                    else v = c - 131072;
                end
                WAVE_SAW: v = longint'(p_carrier >> 16) - 32768;
                WAVE_CUSTOM: v = table_of(p_carrier, 0);
                WAVE_WAVETABLE: v = blend(table_of(p_carrier, lo), table_of(p_carrier, hi), f);
                WAVE_FM: begin
                    m = sine_of(p_fm_phase);
                    off = round_shift(longint'(p_depth) * m * 64'sd683565276, 27);
                    v = sine_of(p_carrier + 32'(off));
                end
                default: begin
                    c = sine_of(p_carrier);
                    m = sine_of(p_ring_phase);
                    prod = round_shift(c * m, 15);
                    v = c + round_shift((prod - c) * longint'(p_mix), 16);
                end
            endcase
            p_carrier = p_carrier + p_step;
            p_fm_phase = p_fm_phase + mod_step(p_fm_ratio);
            p_ring_phase = p_ring_phase + mod_step(p_ring_ratio);
        end
        b = '0;
        b.op = OP_TICK;
        b.slot = 3'($urandom);
        b.idx = 10'($urandom);
        b.val = 16'($urandom);
        beat_q.push_back(b);
        sample_q.push_back(16'(clip16(v)));
        ticks++;
    endtask

    task automatic reg_write(logic [REG_IDX_W-1:0] ri, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {ri, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (ri)
            REG_WAVE_SELECT: p_wave = val[2:0];
            REG_ENABLE: p_enable = val[0];
            REG_PHASE_STEP: p_step = val;
            REG_MORPH: p_morph = clamp17(val, 17'd0, MORPH_MAX);
            REG_FM_RATIO: p_fm_ratio = clamp17(val, RATIO_MIN, RATIO_MAX);
            REG_FM_DEPTH: p_depth = (val[15:0] > DEPTH_MAX) ? DEPTH_MAX : val[15:0];
            REG_RING_RATIO: p_ring_ratio = clamp17(val, RATIO_MIN, RATIO_MAX);
            default: p_mix = clamp17(val, 17'd0, MIX_MAX);
        endcase
    endtask

    task automatic wait_idle();
        while (beat_q.size() != 0 || sample_q.size() != 0 || s_valid) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value(int kind);
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'(kind);
            default: return $urandom;
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        osc_beat_t b;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (beat_q.size() != 0) begin
                b = beat_q.pop_front();
                s_opcode <= b.op;
                s_slot_index <= b.slot;
                s_entry_index <= b.idx;
                s_entry_value <= b.val;
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that alternates between free-running and choppy stretches,
    // with one long hold-off.
    int stall_phase = 0, hold_left = 0;
    logic long_hold_done = 1'b0;
    always @(posedge aclk) begin
        logic signed [15:0] want;
        if (m_valid && m_ready) begin
            samples_seen <= samples_seen + 1;
            if (sample_q.size() == 0) begin
                $display("%0t: unexpected sample beat %0d", $time, m_sample);
                errors <= errors + 1;
            end else begin
                want = sample_q.pop_front();
                if (m_sample !== want) begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, want, m_sample);
                    errors <= errors + 1;
                end
            end
        end
        stall_phase <= stall_phase + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!long_hold_done && samples_seen == 300) begin
            long_hold_done <= 1'b1;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (!aresetn || stall_phase[6]) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= stall_phase[7] ? ($urandom_range(0, 3) != 0) : $urandom_range(0, 1);
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)
                || (beat_q.size() == 0 && sample_q.size() == 0 && !s_valid)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 3000) begin
            $display("tb_multi_waveform_phase_oscillator failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int k, n, ph;
        for (k = 0; k < 1024; k++) sine_lut[k] = sine_poly(32'(k) << 22);
        for (k = 0; k < MEM_DEPTH; k++) begin
            p_mem[k] = '0;
            p_written[k] = 1'b0;
        end
        p_loaded = '0;
        p_wave = WAVE_SINE;
        p_enable = 1'b0;
        p_step = '0;
        p_morph = '0;
        p_fm_ratio = RATIO_RESET;
        p_depth = '0;
        p_ring_ratio = RATIO_RESET;
        p_mix = '0;
        p_carrier = '0;
        p_fm_phase = '0;
        p_ring_phase = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: disabled ticks, writes while disabled, unloaded custom table, extremes.
        push_tick();
        push_write(7, 1023, 16'h8000);
        wait_idle();
        reg_write(REG_ENABLE, 32'd1);
        reg_write(REG_WAVE_SELECT, 32'(WAVE_CUSTOM));
        reg_write(REG_PHASE_STEP, 32'h1234_5679);
        push_tick();
        push_tick();
        push_write(0, 0, 16'h7FFF);
        push_write(0, 1023, 16'h8000);
        push_write(0, 1, 16'h8000);
        push_write(7, 0, 16'h7FFF);
        for (k = 0; k < 4; k++) push_tick();
        wait_idle();
        reg_write(REG_MORPH, 32'h1FFFF);
        reg_write(REG_FM_RATIO, 32'h0);
        reg_write(REG_FM_DEPTH, 32'hFFFF);
        reg_write(REG_RING_RATIO, 32'h1FFFF);
        reg_write(REG_RING_MIX, 32'h1FFFF);
        reg_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
        for (k = 0; k < 8; k++) begin
            wait_idle();
            reg_write(REG_WAVE_SELECT, 32'(k));
            push_tick();
            push_tick();
        end
        wait_idle();
        phases = 2;

        for (ph = 0; ph < 26; ph++) begin
            reg_write(REG_WAVE_SELECT, 32'(ph % 8));
            reg_write(REG_ENABLE, 32'($urandom_range(0, 7) != 0));
            reg_write(REG_PHASE_STEP, (ph % 3 == 0) ? $urandom_range(0, 32'h0100_0000)
                                                    : pick_value(0));
            reg_write(REG_MORPH, pick_value($urandom_range(0, 65536)));
            reg_write(REG_FM_RATIO, pick_value($urandom_range(410, 65536)));
            reg_write(REG_FM_DEPTH, pick_value($urandom_range(0, 40960)));
            reg_write(REG_RING_RATIO, pick_value($urandom_range(410, 65536)));
            reg_write(REG_RING_MIX, pick_value($urandom_range(0, 65536)));
            n = $urandom_range(30, 55);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) < 3) push_write($urandom_range(0, 7),
                                                         $urandom_range(0, 1023), 16'($urandom));
                else push_tick();
            end
            wait_idle();
            phases++;
        end

        $display("Covered %0d ticks and %0d table writes over %0d register phases;",
                 ticks, writes, phases);
        $display("%0d samples checked, %0d mismatches.", samples_seen, errors);
        if (errors == 0) begin
            $display("tb_multi_waveform_phase_oscillator passed");
        end else begin
            $display("tb_multi_waveform_phase_oscillator failed");
        end
        $finish;
    end

endmodule
